/* rtl/htia_pkg.sv */
// Shared types, constants and bit-search helpers for the handle table allocator.
package htia_pkg;

   localparam int ID_BITS     = 12;
   localparam int OBJECT_BITS = 32;
   localparam int ROW_BITS    = 3;
   localparam int ROW_W       = 1 << ROW_BITS;
   localparam int ROWS_BITS   = ID_BITS - ROW_BITS;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_NEXT   = 3'd3;
   localparam logic [2:0] OP_PREV   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   typedef struct packed {
      logic [2:0]             op;
      logic [ID_BITS-1:0]     handle_index;
      logic                   from_end;
      logic [OBJECT_BITS-1:0] object_value;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     result_index;
      logic [OBJECT_BITS-1:0] result_object;
      logic [1:0]             status;
   } rsp_type;

   function automatic logic [ROW_BITS-1:0] lowest_set(input logic [ROW_W-1:0] v);
      logic [ROW_BITS-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) r = ROW_BITS'(i);
      end
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] highest_set(input logic [ROW_W-1:0] v);
      logic [ROW_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (v[i]) r = ROW_BITS'(i);
      end
      return r;
   endfunction

endpackage

/* rtl/handle_table_id_allocator_unit.sv */
// Handle table with rolling ID allocation, occupancy kept in rows of valid bits.
//
// After reset the block sweeps the occupancy memory, one row of 8 entries per
// cycle, with busy high. An operation is taken when start is high and busy
// low; its result appears with rsp_valid for exactly one cycle and cannot be
// held off. Remove and lookup pass through a registered read state and an
// evaluate state before their result. Insert, next and prev scan the
// occupancy memory row by row, each row a registered read and then an
// evaluate step: up to 513 rows for insert on a full table, up to 512 for
// next and prev. Next at the top ID and prev at zero (without from_end) and
// unknown ops are answered from idle. One operation is handled at a time.
module handle_table_id_allocator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  htia_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output htia_pkg::rsp_type rsp_data
);

   localparam int IB = htia_pkg::ID_BITS;
   localparam int RB = htia_pkg::ROW_BITS;
   localparam int RW = htia_pkg::ROW_W;
   localparam int NB = htia_pkg::ROWS_BITS;
   localparam int OB = htia_pkg::OBJECT_BITS;
   localparam logic [NB-1:0] LAST_ROW = '1;

   typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_EVAL} state_type;

   logic [RW-1:0] valid_mem [2**NB];
   logic [OB-1:0] value_mem [2**IB];

   state_type     state_ff, state_in;
   htia_pkg::req_type req_ff, req_in;
   logic [NB-1:0] row_ff, row_in;
   logic [RB-1:0] lo_ff, lo_in;
   logic [NB:0]   cnt_ff, cnt_in;
   logic          first_ff, first_in;
   logic [IB-1:0] next_id_ff, next_id_in;
   logic [NB-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   htia_pkg::rsp_type rsp_ff, rsp_in;

   logic [RW-1:0] vrow_ff;
   logic [OB-1:0] vval_ff;

   logic          vwr_en;
   logic [NB-1:0] vwr_addr;
   logic [RW-1:0] vwr_data;
   logic          owr_en;
   logic [IB-1:0] owr_addr;

   logic [RW-1:0] bit_lo, mask_ge, mask_lt, mask_le, mask, cand;
   logic [RB-1:0] pos;
   logic [IB-1:0] idx_m1, idx_p1;

   always_comb begin
      bit_lo  = RW'(1) << lo_ff;
      mask_lt = bit_lo - RW'(1);
      mask_ge = ~mask_lt;
      mask_le = mask_lt | bit_lo;
      idx_m1  = req_data.handle_index - IB'(1);
      idx_p1  = req_data.handle_index + IB'(1);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      row_in       = row_ff;
      lo_in        = lo_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      next_id_in   = next_id_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      vwr_en       = 1'b0;
      vwr_addr     = row_ff;
      vwr_data     = vrow_ff;
      owr_en       = 1'b0;
      owr_addr     = {row_ff, lo_ff};
      mask         = '1;
      cand         = '0;
      pos          = '0;

      unique case (state_ff)
         S_CLR: begin
            vwr_en   = 1'b1;
            vwr_addr = clr_ff;
            vwr_data = '0;
            clr_in   = clr_ff + NB'(1);
            if (clr_ff == LAST_ROW) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               first_in = 1'b1;
               cnt_in   = '0;
               {row_in, lo_in} = req_data.handle_index;
               state_in = S_RD;
               priority case (req_data.op)
                  htia_pkg::OP_INSERT: {row_in, lo_in} = next_id_ff;
                  htia_pkg::OP_REMOVE, htia_pkg::OP_LOOKUP: ;
                  htia_pkg::OP_NEXT: begin
                     if (req_data.from_end) begin
                        {row_in, lo_in} = '0;
                     end else if (req_data.handle_index == '1) begin
                        state_in      = S_IDLE;
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = htia_pkg::ST_NONE;
                     end else begin
                        {row_in, lo_in} = idx_p1;
                     end
                  end
                  htia_pkg::OP_PREV: begin
                     if (req_data.from_end) begin
                        {row_in, lo_in} = '1;
                     end else if (req_data.handle_index == '0) begin
                        state_in      = S_IDLE;
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = htia_pkg::ST_NONE;
                     end else begin
                        {row_in, lo_in} = idx_m1;
                     end
                  end
                  default: begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_IDLE;
            priority case (req_ff.op)
               htia_pkg::OP_REMOVE: begin
                  rsp_valid_in = 1'b1;
                  if (vrow_ff[lo_ff]) begin
                     vwr_en   = 1'b1;
                     vwr_data = vrow_ff & ~bit_lo;
                  end else begin
                     rsp_in.status = htia_pkg::ST_EMPTY;
                  end
               end
               htia_pkg::OP_LOOKUP: begin
                  rsp_valid_in = 1'b1;
                  if (vrow_ff[lo_ff]) rsp_in.result_object = vval_ff;
                  else rsp_in.status = htia_pkg::ST_EMPTY;
               end
               htia_pkg::OP_INSERT: begin
                  if (cnt_ff == '0) mask = mask_ge;
                  else if (cnt_ff[NB]) mask = mask_lt;
                  cand = ~vrow_ff & mask;
                  pos  = htia_pkg::lowest_set(cand);
                  if (cand != '0) begin
                     vwr_en       = 1'b1;
                     vwr_data     = vrow_ff | (RW'(1) << pos);
                     owr_en       = 1'b1;
                     owr_addr     = {row_ff, pos};
                     next_id_in   = {row_ff, pos} + IB'(1);
                     rsp_valid_in = 1'b1;
                     rsp_in.result_index = {row_ff, pos};
                  end else if (cnt_ff[NB]) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = htia_pkg::ST_FULL;
                  end else begin
                     // wrap around the table, revisiting the start row last
                     row_in   = row_ff + NB'(1);
                     cnt_in   = cnt_ff + (NB+1)'(1);
                     state_in = S_RD;
                  end
               end
               htia_pkg::OP_NEXT: begin
                  if (first_ff) mask = mask_ge;
                  cand = vrow_ff & mask;
                  pos  = htia_pkg::lowest_set(cand);
                  if (cand != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.result_index = {row_ff, pos};
                  end else if (row_ff == LAST_ROW) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = htia_pkg::ST_NONE;
                  end else begin
                     row_in   = row_ff + NB'(1);
                     first_in = 1'b0;
                     state_in = S_RD;
                  end
               end
               default: begin
                  // previous occupied
                  if (first_ff) mask = mask_le;
                  cand = vrow_ff & mask;
                  pos  = htia_pkg::highest_set(cand);
                  if (cand != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.result_index = {row_ff, pos};
                  end else if (row_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = htia_pkg::ST_NONE;
                  end else begin
                     row_in   = row_ff - NB'(1);
                     first_in = 1'b0;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      row_ff   <= row_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (vwr_en) valid_mem[vwr_addr] <= vwr_data;
      if (state_ff == S_RD) vrow_ff <= valid_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (owr_en) value_mem[owr_addr] <= req_ff.object_value;
      if (state_ff == S_RD) vval_ff <= value_mem[{row_ff, lo_ff}];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid_ff || busy))
      else $error("accepted transaction neither answered nor in progress");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ($past(state_ff) == S_RD))
      else $error("evaluation without a preceding memory read");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_EVAL || $past(state_ff) == S_IDLE))
      else $error("result strobe from an unexpected state");

   a_no_rsp_while_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !rsp_valid_ff)
      else $error("result strobe during the clearing sweep");

endmodule
